// ----- rtl/hrs_pkg.sv -----
// Shared widths, register indexes and pipeline payload types of the hue rotator.
package hrs_pkg;

  // Pixel channel width.
  localparam int PIX_W = 8;
  // Quotient width of the hue division (256 hue steps per turn).
  localparam int QUO_W = 8;
  // Sector position base*d+diff lies below 6*d, which needs PIX_W+3 bits.
  localparam int POS_W = PIX_W + 3;
  // Dividend is the position scaled by 128.
  localparam int NUM_W = POS_W + QUO_W - 1;
  // Divisor is 3*d.
  localparam int DEN_W = PIX_W + 2;

  // Configuration port geometry.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Register indexes, taken from paddr[2].
  localparam logic REG_HUE_OFFSET = 1'b0;
  localparam logic REG_SATURATION = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] hue_offset;
    logic [PIX_W-1:0] saturation;
  } hrs_cfg_t;

  // Payload that travels through the divider stages.
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] denom;
    logic [QUO_W-1:0] quot;
    logic             gray;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } hrs_div_t;

endpackage

// ----- rtl/hrs_in_if.sv -----
// Input pixel channel: valid/ready handshake with the RGB payload.
interface hrs_in_if;
  logic                    valid;
  logic                    ready;
  logic [hrs_pkg::PIX_W-1:0] red_in;
  logic [hrs_pkg::PIX_W-1:0] green_in;
  logic [hrs_pkg::PIX_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

// ----- rtl/hrs_out_if.sv -----
// Result pixel channel: valid/ready handshake with the rotated RGB payload and gray flag.
interface hrs_out_if;
  logic                    valid;
  logic                    ready;
  logic [hrs_pkg::PIX_W-1:0] red_out;
  logic [hrs_pkg::PIX_W-1:0] green_out;
  logic [hrs_pkg::PIX_W-1:0] blue_out;
  logic                    passed_gray;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output passed_gray, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input passed_gray, output ready);
endinterface

// ----- rtl/hrs_cfg.sv -----
// APB-style register file holding the hue offset and saturation.
module hrs_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hrs_pkg::CFG_AW-1:0]  paddr,
  input  logic [hrs_pkg::CFG_DW-1:0]  pwdata,
  output logic [hrs_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output hrs_pkg::hrs_cfg_t           cfg
);

  hrs_pkg::hrs_cfg_t cfg_r;
  logic              wr_en;
  logic              reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        hrs_pkg::REG_HUE_OFFSET: cfg_r.hue_offset <= pwdata[hrs_pkg::PIX_W-1:0];
        hrs_pkg::REG_SATURATION: cfg_r.saturation <= pwdata[hrs_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      hrs_pkg::REG_HUE_OFFSET: prdata[hrs_pkg::PIX_W-1:0] = cfg_r.hue_offset;
      hrs_pkg::REG_SATURATION: prdata[hrs_pkg::PIX_W-1:0] = cfg_r.saturation;
      default: ;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/hrs_front.sv -----
// First pipeline stage: max, min, chroma and the scaled sector position of a pixel.
module hrs_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       vld_i,
  output logic                       rdy_o,
  input  logic [hrs_pkg::PIX_W-1:0]  red_i,
  input  logic [hrs_pkg::PIX_W-1:0]  green_i,
  input  logic [hrs_pkg::PIX_W-1:0]  blue_i,
  output logic                       vld_o,
  input  logic                       rdy_i,
  output hrs_pkg::hrs_div_t          dat_o
);

  logic                      vld_r;
  hrs_pkg::hrs_div_t         dat_r;
  hrs_pkg::hrs_div_t         dat_nxt;
  logic                      red_max;
  logic                      green_max;
  logic [hrs_pkg::PIX_W-1:0] mx;
  logic [hrs_pkg::PIX_W-1:0] mn;
  logic [hrs_pkg::PIX_W-1:0] chroma;
  logic [hrs_pkg::POS_W-1:0] d_w;
  logic [hrs_pkg::POS_W-1:0] pos;

  always_comb begin
    // Ties go to red first, then green.
    red_max   = (red_i >= green_i) && (red_i >= blue_i);
    green_max = !red_max && (green_i >= blue_i);
    mx = red_max ? red_i : (green_max ? green_i : blue_i);
    if ((red_i <= green_i) && (red_i <= blue_i)) begin
      mn = red_i;
    end else if (green_i <= blue_i) begin
      mn = green_i;
    end else begin
      mn = blue_i;
    end
    chroma = mx - mn;
    d_w    = hrs_pkg::POS_W'(chroma);

    if (red_max) begin
      if (green_i >= blue_i) begin
        pos = hrs_pkg::POS_W'(green_i - blue_i);
      end else begin
        pos = (d_w << 2) + (d_w << 1) - hrs_pkg::POS_W'(blue_i - green_i);
      end
    end else if (green_max) begin
      pos = (d_w << 1) + hrs_pkg::POS_W'(blue_i) - hrs_pkg::POS_W'(red_i);
    end else begin
      pos = (d_w << 2) + hrs_pkg::POS_W'(red_i) - hrs_pkg::POS_W'(green_i);
    end

    dat_nxt.rem   = {pos, {(hrs_pkg::QUO_W-1){1'b0}}};
    dat_nxt.denom = (hrs_pkg::DEN_W'(chroma) << 1) + hrs_pkg::DEN_W'(chroma);
    dat_nxt.quot  = '0;
    dat_nxt.gray  = (mx == mn);
    dat_nxt.red   = red_i;
    dat_nxt.green = green_i;
    dat_nxt.blue  = blue_i;
  end

  assign rdy_o = !vld_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

endmodule

// ----- rtl/hrs_div.sv -----
// Pipelined restoring divider: one hue quotient bit per register stage.
module hrs_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_i,
  output logic               rdy_o,
  input  hrs_pkg::hrs_div_t  dat_i,
  output logic               vld_o,
  input  logic               rdy_i,
  output hrs_pkg::hrs_div_t  dat_o
);

  logic [hrs_pkg::QUO_W:0] vld;
  logic [hrs_pkg::QUO_W:0] rdy;
  hrs_pkg::hrs_div_t       dat [hrs_pkg::QUO_W+1];

  assign vld[0]              = vld_i;
  assign dat[0]              = dat_i;
  assign rdy[hrs_pkg::QUO_W] = rdy_i;
  assign rdy_o               = rdy[0];

  for (genvar gv = 0; gv < hrs_pkg::QUO_W; gv++) begin : g_stage
    localparam int SH = hrs_pkg::QUO_W - 1 - gv;

    logic                      vld_r;
    hrs_pkg::hrs_div_t         dat_r;
    hrs_pkg::hrs_div_t         dat_nxt;
    logic [hrs_pkg::NUM_W-1:0] sub;
    logic                      fits;

    // The quotient is known to stay below 2**QUO_W, so the remainder
    // never needs a wider divisor than denom shifted by QUO_W-1.
    assign sub  = hrs_pkg::NUM_W'(dat[gv].denom) << SH;
    assign fits = dat[gv].rem >= sub;

    always_comb begin
      dat_nxt = dat[gv];
      if (fits) begin
        dat_nxt.rem      = dat[gv].rem - sub;
        dat_nxt.quot[SH] = 1'b1;
      end
    end

    assign rdy[gv] = !vld_r || rdy[gv+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (rdy[gv]) begin
        vld_r <= vld[gv];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[gv] && vld[gv]) begin
        dat_r <= dat_nxt;
      end
    end

    assign vld[gv+1] = vld_r;
    assign dat[gv+1] = dat_r;
  end

  assign vld_o = vld[hrs_pkg::QUO_W];
  assign dat_o = dat[hrs_pkg::QUO_W];

endmodule

// ----- rtl/hrs_back.sv -----
// Back end: hue offset, HSV levels with two multipliers, sector mux and output register.
module hrs_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hrs_pkg::hrs_cfg_t          cfg,
  input  logic                       vld_i,
  output logic                       rdy_o,
  input  hrs_pkg::hrs_div_t          dat_i,
  output logic                       vld_o,
  input  logic                       rdy_i,
  output logic [hrs_pkg::PIX_W-1:0]  red_o,
  output logic [hrs_pkg::PIX_W-1:0]  green_o,
  output logic [hrs_pkg::PIX_W-1:0]  blue_o,
  output logic                       gray_o
);

  typedef enum logic [2:0] {
    SEC_RED_YEL  = 3'd0,
    SEC_YEL_GRN  = 3'd1,
    SEC_GRN_CYN  = 3'd2,
    SEC_CYN_BLU  = 3'd3,
    SEC_BLU_MAG  = 3'd4,
    SEC_MAG_RED  = 3'd5
  } hrs_sector_t;

  typedef struct packed {
    logic [2:0]                sector;
    logic [hrs_pkg::PIX_W-1:0] pv;
    logic [hrs_pkg::PIX_W-1:0] qv;
    logic [hrs_pkg::PIX_W-1:0] tv;
    logic                      gray;
    logic [hrs_pkg::PIX_W-1:0] red;
    logic [hrs_pkg::PIX_W-1:0] green;
    logic [hrs_pkg::PIX_W-1:0] blue;
  } hrs_lvl_t;

  typedef struct packed {
    logic [hrs_pkg::PIX_W-1:0] red;
    logic [hrs_pkg::PIX_W-1:0] green;
    logic [hrs_pkg::PIX_W-1:0] blue;
    logic                      gray;
  } hrs_pix_t;

  localparam logic [hrs_pkg::PIX_W-1:0] FULL = '1;

  logic                        lvl_vld_r;
  hrs_lvl_t                    lvl_r;
  hrs_lvl_t                    lvl_nxt;
  logic                        out_vld_r;
  hrs_pix_t                    out_r;
  hrs_pix_t                    out_nxt;
  logic                        lvl_rdy;
  logic [hrs_pkg::QUO_W-1:0]   hue;
  logic [hrs_pkg::QUO_W-3:0]   hue6;
  logic [hrs_pkg::PIX_W-1:0]   h3;
  logic [hrs_pkg::PIX_W-1:0]   frac;
  logic [2*hrs_pkg::PIX_W-1:0] prod_f;
  logic [2*hrs_pkg::PIX_W-1:0] prod_t;

  // Level stage: rotated hue, sector and the p/q/t levels.
  always_comb begin
    hue    = dat_i.quot + cfg.hue_offset;
    hue6   = hue[hrs_pkg::QUO_W-1:2];
    h3     = hrs_pkg::PIX_W'(hue6) + hrs_pkg::PIX_W'({hue6, 1'b0});
    frac   = {h3[4:0], 3'b000};
    prod_f = cfg.saturation * frac;
    prod_t = cfg.saturation * (FULL - frac);

    lvl_nxt.sector = h3[7:5];
    lvl_nxt.pv     = ~cfg.saturation;
    lvl_nxt.qv     = ~prod_f[2*hrs_pkg::PIX_W-1:hrs_pkg::PIX_W];
    lvl_nxt.tv     = ~prod_t[2*hrs_pkg::PIX_W-1:hrs_pkg::PIX_W];
    lvl_nxt.gray   = dat_i.gray;
    lvl_nxt.red    = dat_i.red;
    lvl_nxt.green  = dat_i.green;
    lvl_nxt.blue   = dat_i.blue;
  end

  // Output stage: channel assignment per sector, gray pixels pass unchanged.
  always_comb begin
    out_nxt.gray = lvl_r.gray;
    if (lvl_r.gray) begin
      out_nxt.red   = lvl_r.red;
      out_nxt.green = lvl_r.green;
      out_nxt.blue  = lvl_r.blue;
    end else begin
      unique case (hrs_sector_t'(lvl_r.sector))
        SEC_RED_YEL: begin
          out_nxt.red = FULL;     out_nxt.green = lvl_r.tv; out_nxt.blue = lvl_r.pv;
        end
        SEC_YEL_GRN: begin
          out_nxt.red = lvl_r.qv; out_nxt.green = FULL;     out_nxt.blue = lvl_r.pv;
        end
        SEC_GRN_CYN: begin
          out_nxt.red = lvl_r.pv; out_nxt.green = FULL;     out_nxt.blue = lvl_r.tv;
        end
        SEC_CYN_BLU: begin
          out_nxt.red = lvl_r.pv; out_nxt.green = lvl_r.qv; out_nxt.blue = FULL;
        end
        SEC_BLU_MAG: begin
          out_nxt.red = lvl_r.tv; out_nxt.green = lvl_r.pv; out_nxt.blue = FULL;
        end
        default: begin
          out_nxt.red = FULL;     out_nxt.green = lvl_r.pv; out_nxt.blue = lvl_r.qv;
        end
      endcase
    end
  end

  assign lvl_rdy = !out_vld_r || rdy_i;
  assign rdy_o   = !lvl_vld_r || lvl_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (rdy_o) begin
        lvl_vld_r <= vld_i;
      end
      if (lvl_rdy) begin
        out_vld_r <= lvl_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      lvl_r <= lvl_nxt;
    end
    if (lvl_rdy && lvl_vld_r) begin
      out_r <= out_nxt;
    end
  end

  assign vld_o   = out_vld_r;
  assign red_o   = out_r.red;
  assign green_o = out_r.green;
  assign blue_o  = out_r.blue;
  assign gray_o  = out_r.gray;

endmodule

// ----- rtl/rgb_hue_rotate_saturate_core.sv -----
// Top level of the RGB hue rotator with saturation control.
//
// Each 8-bit RGB pixel comes back with its hue turned by hue_offset (256
// steps per full turn) and rebuilt at full value with the programmed
// saturation; a gray pixel (all channels equal) comes back unchanged with
// passed_gray set. The block takes one pixel per clock while the output
// side is not stalled and holds eleven beats in flight: one stage finds
// max, min and the sector position, eight stages run the exact hue
// division one quotient bit each, one stage adds the offset and forms the
// HSV levels with two 8x8 multipliers, and the last stage is the output
// register. Each stage has its own valid bit and moves whenever the next
// stage is empty or moving, so empty slots close up during an output stall
// and the input keeps accepting until the pipeline is truly full. Registers
// sit at byte address 0 (hue_offset) and 4 (saturation), low 8 bits of the
// data; write them only while no pixel is in flight.
module rgb_hue_rotate_saturate_core (
  input  logic                        clk,
  input  logic                        rst_n,
  hrs_in_if.sink                      in_px,
  hrs_out_if.source                   out_px,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [hrs_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [hrs_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [hrs_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  hrs_pkg::hrs_cfg_t cfg;
  logic              front_vld;
  logic              front_rdy;
  hrs_pkg::hrs_div_t front_dat;
  logic              div_vld;
  logic              div_rdy;
  hrs_pkg::hrs_div_t div_dat;

  hrs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Max/min and the scaled sector position, ready for division by 3*d.
  hrs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (in_px.valid),
    .rdy_o   (in_px.ready),
    .red_i   (in_px.red_in),
    .green_i (in_px.green_in),
    .blue_i  (in_px.blue_in),
    .vld_o   (front_vld),
    .rdy_i   (front_rdy),
    .dat_o   (front_dat)
  );

  // Exact integer hue: floor(128*pos / (3*d)), always below 256.
  hrs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (front_vld),
    .rdy_o (front_rdy),
    .dat_i (front_dat),
    .vld_o (div_vld),
    .rdy_i (div_rdy),
    .dat_o (div_dat)
  );

  // Offset, HSV levels, per-sector channel assignment and output register.
  hrs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .vld_i   (div_vld),
    .rdy_o   (div_rdy),
    .dat_i   (div_dat),
    .vld_o   (out_px.valid),
    .rdy_i   (out_px.ready),
    .red_o   (out_px.red_out),
    .green_o (out_px.green_out),
    .blue_o  (out_px.blue_out),
    .gray_o  (out_px.passed_gray)
  );

endmodule

// ----- bench/hrs_pixel_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the hue rotator: snoops the register port, predicts each pixel, checks results.
module hrs_pixel_checker
  import hrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  hrs_in_if                 in_mon,
  hrs_out_if                out_mon,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  input  logic [CFG_DW-1:0] cfg_prdata,
  input  logic              cfg_pready,
  output int                mismatch_count,
  output int                pixels_in_flight
);

  localparam int MAX_REPORTS = 40;
  localparam int unsigned FULL_LEVEL = 255;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
    logic gray;
  } rotated_pixel_t;

  typedef enum int unsigned {
    SEC_RED_YELLOW     = 0,
    SEC_YELLOW_GREEN   = 1,
    SEC_GREEN_CYAN     = 2,
    SEC_CYAN_BLUE      = 3,
    SEC_BLUE_MAGENTA   = 4,
    SEC_MAGENTA_RED    = 5
  } hue_sector_e;

  pix_t           hue_offset_q = '0;
  pix_t           saturation_q = '0;
  rotated_pixel_t expected_pixels[$];
  rotated_pixel_t want;
  int             errors = 0;

  // Exact integer hue, offset with wrap, then HSV rebuild at full value.
  function automatic rotated_pixel_t rotate_pixel(input pix_t r, input pix_t g, input pix_t b,
                                                  input pix_t offset, input pix_t sat);
    rotated_pixel_t res;
    int unsigned    ri, gi, bi, mx, mn, d, pos, num, q, h, f, s, pv, qv, tv, ro, go, bo;
    hue_sector_e    sector;
    ri = r;
    gi = g;
    bi = b;
    mx = (ri > gi) ? ri : gi;
    mx = (mx > bi) ? mx : bi;
    mn = (ri < gi) ? ri : gi;
    mn = (mn < bi) ? mn : bi;
    res.red   = r;
    res.green = g;
    res.blue  = b;
    res.gray  = 1'b1;
    if (mx == mn) begin
      return res;
    end
    d = mx - mn;
    // Red wins ties over green, green over blue.
    if (mx == ri) begin
      pos = (gi >= bi) ? gi - bi : 6 * d - (bi - gi);
    end else if (mx == gi) begin
      pos = 2 * d + bi - ri;
    end else begin
      pos = 4 * d + ri - gi;
    end
    num = pos * 128 + offset * 3 * d;
    q   = (num / (3 * d)) & FULL_LEVEL;
    h   = (q >> 2) * 3;
    sector = hue_sector_e'(h >> 5);
    f  = (h & 31) << 3;
    s  = sat;
    pv = FULL_LEVEL - s;
    qv = FULL_LEVEL - ((s * f) >> 8);
    tv = FULL_LEVEL - ((s * (FULL_LEVEL - f)) >> 8);
    case (sector)
      SEC_RED_YELLOW: begin
        ro = FULL_LEVEL; go = tv;         bo = pv;
      end
      SEC_YELLOW_GREEN: begin
        ro = qv;         go = FULL_LEVEL; bo = pv;
      end
      SEC_GREEN_CYAN: begin
        ro = pv;         go = FULL_LEVEL; bo = tv;
      end
      SEC_CYAN_BLUE: begin
        ro = pv;         go = qv;         bo = FULL_LEVEL;
      end
      SEC_BLUE_MAGENTA: begin
        ro = tv;         go = pv;         bo = FULL_LEVEL;
      end
      default: begin
        ro = FULL_LEVEL; go = pv;         bo = qv;
      end
    endcase
    res.red   = pix_t'(ro);
    res.green = pix_t'(go);
    res.blue  = pix_t'(bo);
    res.gray  = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [CFG_DW-1:0] got,
                                 input logic [CFG_DW-1:0] exp_val);
    if (errors < MAX_REPORTS) begin
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
    end
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hue_offset_q = '0;
      saturation_q = '0;
      expected_pixels.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("result beat with nothing pending", '0, '0);
        end else begin
          want = expected_pixels.pop_front();
          if (out_mon.red_out !== want.red) begin
            report_mismatch("red_out", out_mon.red_out, want.red);
          end
          if (out_mon.green_out !== want.green) begin
            report_mismatch("green_out", out_mon.green_out, want.green);
          end
          if (out_mon.blue_out !== want.blue) begin
            report_mismatch("blue_out", out_mon.blue_out, want.blue);
          end
          if (out_mon.passed_gray !== want.gray) begin
            report_mismatch("passed_gray", out_mon.passed_gray, want.gray);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_pixels.push_back(rotate_pixel(in_mon.red_in, in_mon.green_in, in_mon.blue_in,
                                               hue_offset_q, saturation_q));
      end
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (cfg_paddr[2] == REG_HUE_OFFSET) begin
            hue_offset_q = cfg_pwdata[PIX_W-1:0];
          end else begin
            saturation_q = cfg_pwdata[PIX_W-1:0];
          end
        end else if (cfg_paddr[2] == REG_HUE_OFFSET) begin
          if (cfg_prdata !== {{(CFG_DW-PIX_W){1'b0}}, hue_offset_q}) begin
            report_mismatch("hue_offset readback", cfg_prdata, hue_offset_q);
          end
        end else begin
          if (cfg_prdata !== {{(CFG_DW-PIX_W){1'b0}}, saturation_q}) begin
            report_mismatch("saturation readback", cfg_prdata, saturation_q);
          end
        end
      end
    end
    pixels_in_flight <= expected_pixels.size();
    mismatch_count   <= errors;
  end

endmodule

// ----- bench/rgb_hue_rotate_saturate_core_tb.sv -----
`timescale 1ns / 1ps
// Top of the hue rotator bench: clock, reset, register traffic, pixel traffic and verdict.
module rgb_hue_rotate_saturate_core_tb;
  import hrs_pkg::*;

  // Minimum number of random pixels, spread over phases with different register settings.
  localparam int RANDOM_PIXELS = 1750;
  // The pipeline holds eleven beats; these cycles settle the end.
  localparam int SETTLE_CYCLES = 16;
  // Guard time in ns: the slowest legal run (longest gaps and stalls on every beat)
  // stays well below a quarter of this.
  localparam longint TIMEOUT_NS = 10_000_000;

  localparam logic [CFG_AW-1:0] ADDR_HUE_OFFSET = {REG_HUE_OFFSET, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_SATURATION = {REG_SATURATION, 2'b00};

  typedef logic [PIX_W-1:0] pixel_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  int                mismatch_count;
  int                pixels_in_flight;
  int                send_burst_left = 0;

  hrs_in_if  in_px ();
  hrs_out_if out_px ();

  always #5 clk = ~clk;

  rgb_hue_rotate_saturate_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_px       (in_px),
    .out_px      (out_px),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // The checker sees the same channels and register port as the block does and
  // keeps its own copy of the registers from the writes it observes.
  hrs_pixel_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mon           (in_px),
    .out_mon          (out_px),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready),
    .mismatch_count   (mismatch_count),
    .pixels_in_flight (pixels_in_flight)
  );

  // Idle length shared by both sides: mostly none or short, now and then long.
  function automatic int idle_length();
    int k;
    k = $urandom_range(99);
    if (k < 45) begin
      return 0;
    end else if (k < 85) begin
      return $urandom_range(3, 1);
    end else if (k < 97) begin
      return $urandom_range(12, 4);
    end
    return $urandom_range(60, 20);
  endfunction

  // The sender sometimes runs a stretch of back-to-back beats with no gaps at all.
  function automatic int sender_gap();
    if (send_burst_left > 0) begin
      send_burst_left--;
      return 0;
    end
    if ($urandom_range(99) < 4) begin
      send_burst_left = $urandom_range(120, 30);
    end
    return idle_length();
  endfunction

  function automatic pixel_t extreme_level();
    case ($urandom_range(4))
      0:       return pixel_t'(0);
      1:       return pixel_t'(1);
      2:       return pixel_t'(254);
      3:       return pixel_t'(255);
      default: return pixel_t'($urandom_range(255));
    endcase
  endfunction

  // Every task below is entered and left at a rising edge, so the nonblocking
  // assignments it makes line up with the edges that the block samples.

  // One input beat. When no gap is drawn, valid simply stays high and only the
  // payload changes, so valid never sees two assignments in one time step.
  task automatic send_pixel(input pixel_t r, input pixel_t g, input pixel_t b);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_px.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_px.valid    <= 1'b1;
    in_px.red_in   <= r;
    in_px.green_in <= g;
    in_px.blue_in  <= b;
    @(posedge clk);
    while (!in_px.ready) @(posedge clk);
  endtask

  // Stops the input and waits until the checker has seen every result come back.
  // One edge passes first so that the beat accepted just now is counted.
  task automatic drain_pixels();
    in_px.valid <= 1'b0;
    @(posedge clk);
    while (pixels_in_flight != 0) @(posedge clk);
  endtask

  // Setup cycle, access cycle, then the bus goes idle. The upper data bits
  // carry random junk, which the block must ignore.
  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input pixel_t value);
    logic [CFG_DW-1:0] word;
    word = $urandom();
    word[PIX_W-1:0] = value;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // The checker compares prdata in the access cycle.
  task automatic cfg_read(input logic [CFG_AW-1:0] addr);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Registers change only with the pipeline empty; both are read back afterwards.
  task automatic set_config(input bit do_hue, input pixel_t hue, input bit do_sat,
                            input pixel_t sat);
    drain_pixels();
    if (do_hue) begin
      cfg_write(ADDR_HUE_OFFSET, hue);
    end
    if (do_sat) begin
      cfg_write(ADDR_SATURATION, sat);
    end
    cfg_read(ADDR_HUE_OFFSET);
    cfg_read(ADDR_SATURATION);
  endtask

  // Random pixel drawn from a mix of shapes: fully random, gray, ties for the
  // maximum, nearly gray (tiny max-min, where the division is most delicate)
  // and channels at or near the ends of the range.
  task automatic random_pixel(output pixel_t r, output pixel_t g, output pixel_t b);
    int     kind;
    int     base;
    pixel_t hi;
    pixel_t lo;
    kind = $urandom_range(99);
    r = pixel_t'($urandom_range(255));
    g = pixel_t'($urandom_range(255));
    b = pixel_t'($urandom_range(255));
    if (kind < 55) begin
      // Keep the fully random channels.
    end else if (kind < 63) begin
      g = r;
      b = r;
    end else if (kind < 75) begin
      hi = pixel_t'($urandom_range(255, 1));
      lo = pixel_t'($urandom_range(int'(hi) - 1, 0));
      case ($urandom_range(2))
        0: begin
          r = hi; g = hi; b = lo;
        end
        1: begin
          r = lo; g = hi; b = hi;
        end
        default: begin
          r = hi; g = lo; b = hi;
        end
      endcase
    end else if (kind < 87) begin
      base = $urandom_range(253);
      r = pixel_t'(base + $urandom_range(2));
      g = pixel_t'(base + $urandom_range(2));
      b = pixel_t'(base + $urandom_range(2));
    end else begin
      r = extreme_level();
      g = extreme_level();
      b = extreme_level();
    end
  endtask

  // Result side: ready high for a run of cycles, then low for an idle stretch.
  // A zero-length stall leaves ready high, so it is never lowered and raised
  // again in the same time step.
  initial begin
    int on_cycles;
    int off_cycles;
    out_px.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(99) < 8) begin
        on_cycles = $urandom_range(300, 100);
      end else begin
        on_cycles = $urandom_range(8, 1);
      end
      off_cycles = idle_length();
      out_px.ready <= 1'b1;
      repeat (on_cycles) @(posedge clk);
      if (off_cycles > 0) begin
        out_px.ready <= 1'b0;
        repeat (off_cycles) @(posedge clk);
      end
    end
  end

  // Main sequence: reset, directed pixels, then random phases, then the verdict.
  initial begin
    pixel_t r;
    pixel_t g;
    pixel_t b;
    int     sent;
    int     phase;
    int     count;
    bit     do_hue;
    bit     do_sat;
    pixel_t hue;
    pixel_t sat;

    rst_n          <= 1'b0;
    in_px.valid    <= 1'b0;
    in_px.red_in   <= '0;
    in_px.green_in <= '0;
    in_px.blue_in  <= '0;
    cfg_psel       <= 1'b0;
    cfg_penable    <= 1'b0;
    cfg_pwrite     <= 1'b0;
    cfg_paddr      <= '0;
    cfg_pwdata     <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Both registers must read back as zero after reset.
    cfg_read(ADDR_HUE_OFFSET);
    cfg_read(ADDR_SATURATION);

    // A few pixels under the reset settings: zero saturation turns every
    // colored pixel white, while gray pixels still pass through.
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);

    // Full saturation, no rotation: the hue computation shows up directly.
    set_config(1'b1, 8'd0, 1'b1, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd0);
    // Ties for the maximum: red over green, green over blue, red over blue.
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    // Red maximum with blue above green lands in the top of the hue circle; with green above blue, at the bottom.
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd1, 8'd0);
    send_pixel(8'd255, 8'd254, 8'd255);
    // Smallest possible spread between max and min, then other hues with wide spreads and a gray pixel.
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd128, 8'd128, 8'd127);
    send_pixel(8'd127, 8'd128, 8'd128);
    send_pixel(8'd254, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd254, 8'd255);
    send_pixel(8'd85, 8'd170, 8'd255);
    send_pixel(8'd170, 8'd85, 8'd0);
    send_pixel(8'd1, 8'd1, 8'd1);

    // Largest offset: hues near the top of the circle wrap around to red.
    set_config(1'b1, 8'd255, 1'b1, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd128);
    send_pixel(8'd0, 8'd0, 8'd255);

    // Random phases. The first five use fixed settings, mostly at the ends of
    // the register ranges; later ones rewrite one or both registers at random.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_PIXELS) begin
      case (phase)
        0: set_config(1'b1, 8'd255, 1'b1, 8'd255);
        1: set_config(1'b1, 8'd0, 1'b1, 8'd0);
        2: set_config(1'b1, 8'd128, 1'b1, 8'd255);
        3: set_config(1'b1, 8'd1, 1'b1, 8'd128);
        4: set_config(1'b1, 8'd255, 1'b1, 8'd0);
        default: begin
          do_hue = ($urandom_range(1) == 1);
          do_sat = !do_hue || ($urandom_range(1) == 1);
          hue = ($urandom_range(99) < 15) ? extreme_level() : pixel_t'($urandom_range(255));
          sat = ($urandom_range(99) < 15) ? extreme_level() : pixel_t'($urandom_range(255));
          set_config(do_hue, hue, do_sat, sat);
        end
      endcase
      count = $urandom_range(200, 40);
      for (int i = 0; i < count; i++) begin
        // Once, in the middle of a phase, the sender holds off until the
        // pipeline has completely emptied, then resumes.
        if (phase == 2 && i == count / 2) begin
          drain_pixels();
        end
        random_pixel(r, g, b);
        send_pixel(r, g, b);
      end
      sent += count;
      phase++;
    end

    // Every result must come back; a missing one ends in the timeout instead.
    drain_pixels();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule
